### rtl/scratchpad_tape_spill_allocator_macros.svh
// ----------------------------------------------------------------------------
// Scratchpad tape spill allocator: assertion macros
// Shared assertion forms, clocked on clk and disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef SCRATCHPAD_TAPE_SPILL_ALLOCATOR_MACROS_SVH
`define SCRATCHPAD_TAPE_SPILL_ALLOCATOR_MACROS_SVH

// Check that cons holds in the same cycle as ante
`define STSA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("stsa: same-cycle check failed");

// Check that cons holds in the cycle after ante
`define STSA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("stsa: next-cycle check failed");

`endif

### rtl/stsa_pkg.sv
// ----------------------------------------------------------------------------
// Scratchpad tape spill allocator package
// Widths, codes and word types shared by the allocator modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package stsa_pkg;

  // Spill history stack geometry
  localparam int HIST_DEPTH  = 64;
  localparam int HIST_CNT_W  = $clog2(HIST_DEPTH + 1);
  localparam int HIST_ADDR_W = $clog2(HIST_DEPTH);

  // Field widths
  localparam int ADDR_W  = 32;
  localparam int FILL_W  = 22;
  localparam int SIZE_W  = 21;
  localparam int ALLOC_W = 20;
  localparam int INDEX_W = 16;

  localparam logic [FILL_W-1:0] FILL_MAX = {FILL_W{1'b1}};
  localparam logic [SIZE_W-1:0] SIZE_MAX = {SIZE_W{1'b1}};

  // Request kinds
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_ADDR  = 1'b1;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REGION_START = 2'd0,
    CFG_SPILL_LIMIT  = 2'd1,
    CFG_TAPE_BASE    = 2'd2,
    CFG_REVERSE_MODE = 2'd3
  } cfg_idx_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic               req_type;
    logic [ALLOC_W-1:0] alloc_size;
    logic [INDEX_W-1:0] elem_index;
  } in_word_t;

  typedef struct packed {
    logic              mem_valid;
    logic              mem_write;
    logic [ADDR_W-1:0] mem_addr;
    logic [SIZE_W-1:0] mem_size;
    logic [ADDR_W-1:0] head_addr;
    logic [ADDR_W-1:0] access_addr;
    status_t           status;
  } out_word_t;

  typedef struct packed {
    logic [ADDR_W-1:0] region_start;
    logic [SIZE_W-1:0] spill_limit;
    logic [ADDR_W-1:0] tape_base;
    logic              reverse_mode;
  } cfg_t;

  // Stack command from the allocator core
  typedef struct packed {
    logic              push;
    logic              pop;
    logic [SIZE_W-1:0] wdata;
  } hist_cmd_t;

  // Stack state seen by the allocator core
  typedef struct packed {
    logic [HIST_CNT_W-1:0] count;
    logic [SIZE_W-1:0]     top;
  } hist_stat_t;

endpackage

`default_nettype wire

### rtl/stsa_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, then register the read word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/stsa_hist.sv
// ----------------------------------------------------------------------------
// Spill history stack
// Size stack with the top entry held in a register and the entry below it
// prefetched from RAM, so a pop can follow any operation in the next cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stsa_hist import stsa_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire hist_cmd_t  cmd,
  output hist_stat_t      stat
);

  logic [HIST_CNT_W-1:0]  count;
  logic [HIST_CNT_W-1:0]  count_next;
  logic [SIZE_W-1:0]      top;
  logic [SIZE_W-1:0]      below;
  logic [HIST_CNT_W-1:0]  raddr_full;

  // Advance the entry count
  always_comb begin
    count_next = count;
    if (cmd.push) begin
      count_next = count + HIST_CNT_W'(1);
    end else if (cmd.pop) begin
      count_next = count - HIST_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // Hold the top entry; on pop the prefetched entry below becomes the top
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      top <= cmd.wdata;
    end else if (cmd.pop) begin
      top <= below;
    end
  end

  // Prefetch the entry below the next top
  assign raddr_full = count_next - HIST_CNT_W'(2);

  stsa_ram #(
    .WIDTH (SIZE_W),
    .DEPTH (HIST_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.push),
    .waddr (count[HIST_ADDR_W-1:0]),
    .wdata (cmd.wdata),
    .raddr (raddr_full[HIST_ADDR_W-1:0]),
    .rdata (below)
  );

  assign stat.count = count;
  assign stat.top   = top;

endmodule

`default_nettype wire

### rtl/stsa_core.sv
// ----------------------------------------------------------------------------
// Allocator core
// Region fill, frame head and tape pointer, and the result of one word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stsa_core import stsa_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       fire,
  input  wire in_word_t   item,
  input  wire cfg_t       cfg,
  input  wire hist_stat_t hist_stat,
  output hist_cmd_t       hist_cmd,
  output out_word_t       result
);

  logic [FILL_W-1:0] region_fill;
  logic [FILL_W-1:0] region_fill_next;
  logic [FILL_W-1:0] head_offset;
  logic [FILL_W-1:0] head_offset_next;
  logic [ADDR_W-1:0] tape_offset;
  logic [ADDR_W-1:0] tape_offset_next;

  logic [FILL_W:0]   grow_sum;
  logic              spill_hit;
  logic [SIZE_W-1:0] spill_size;
  logic [FILL_W-1:0] fill_eff;
  logic [FILL_W:0]   grow_eff;
  logic [FILL_W-1:0] alloc_ext;
  logic              hist_full;
  logic              hist_empty;

  assign alloc_ext  = FILL_W'(item.alloc_size);
  assign grow_sum   = {1'b0, region_fill} + {1'b0, alloc_ext};
  assign spill_hit  = grow_sum >= (FILL_W + 1)'(cfg.spill_limit);
  assign spill_size = (region_fill > FILL_W'(SIZE_MAX)) ? SIZE_MAX
                                                        : region_fill[SIZE_W-1:0];
  assign hist_full  = hist_stat.count >= HIST_CNT_W'(HIST_DEPTH);
  assign hist_empty = hist_stat.count == '0;

  // Decide the spill or refill and the next region state
  always_comb begin
    region_fill_next = region_fill;
    head_offset_next = head_offset;
    tape_offset_next = tape_offset;
    fill_eff         = region_fill;
    grow_eff         = '0;
    hist_cmd         = '0;
    result           = '0;
    result.status    = ST_OK;

    if (item.req_type == REQ_ADDR) begin
      result.access_addr = cfg.region_start + ADDR_W'(head_offset)
                         + ADDR_W'({item.elem_index, 3'b000});
    end else if (!cfg.reverse_mode) begin
      // Forward: spill the region when the request would reach the limit
      if (spill_hit) begin
        if (hist_full) begin
          result.status = ST_FULL;
        end else begin
          result.mem_valid = 1'b1;
          result.mem_write = 1'b1;
          result.mem_addr  = cfg.tape_base + tape_offset;
          result.mem_size  = spill_size;
          hist_cmd.push    = 1'b1;
          hist_cmd.wdata   = spill_size;
          tape_offset_next = tape_offset + ADDR_W'(spill_size);
          fill_eff         = '0;
        end
      end
      head_offset_next = fill_eff;
      grow_eff         = {1'b0, fill_eff} + {1'b0, alloc_ext};
      region_fill_next = grow_eff[FILL_W] ? FILL_MAX : grow_eff[FILL_W-1:0];
    end else begin
      // Reverse: refill an empty region from the last spill
      if (region_fill == '0) begin
        if (hist_empty) begin
          result.status = ST_EMPTY;
        end else begin
          tape_offset_next = tape_offset - ADDR_W'(hist_stat.top);
          result.mem_valid = 1'b1;
          result.mem_addr  = cfg.tape_base + tape_offset_next;
          result.mem_size  = hist_stat.top;
          hist_cmd.pop     = 1'b1;
          fill_eff         = FILL_W'(hist_stat.top);
        end
      end
      region_fill_next = (fill_eff > alloc_ext) ? fill_eff - alloc_ext : '0;
      head_offset_next = region_fill_next;
    end

    result.head_addr = cfg.region_start + ADDR_W'(head_offset_next);

    // Drop stack commands unless the word is taken
    if (!fire) begin
      hist_cmd.push = 1'b0;
      hist_cmd.pop  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      region_fill <= '0;
      head_offset <= '0;
      tape_offset <= '0;
    end else if (fire) begin
      region_fill <= region_fill_next;
      head_offset <= head_offset_next;
      tape_offset <= tape_offset_next;
    end
  end

endmodule

`default_nettype wire

### rtl/scratchpad_tape_spill_allocator.sv
// Throughput: one word per cycle while the output is not stalled; the pop path reads a
// top-of-stack register while the RAM prefetches the entry below it, so back-to-back
// pops need no wait.
// Reset (synchronous, active high) clears fill, head, tape pointer, stack count and the
// valid flags, and loads the register defaults; the history RAM is not cleared.
// ----------------------------------------------------------------------------
// Scratchpad tape spill allocator
// Frame allocator over a scratchpad region that spills to and refills from a
// backing tape, with an input register and an output register around the core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "scratchpad_tape_spill_allocator_macros.svh"

module scratchpad_tape_spill_allocator import stsa_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire in_word_t             in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output out_word_t                 out_data,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ADDR_W-1:0]    cfg_data
);

  cfg_t       cfg;
  logic       in_q_valid;
  in_word_t   in_q;
  logic       fire;
  hist_cmd_t  hist_cmd;
  hist_stat_t hist_stat;
  out_word_t  result;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.region_start <= '0;
      cfg.spill_limit  <= SIZE_W'(65536);
      cfg.tape_base    <= '0;
      cfg.reverse_mode <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_REGION_START: cfg.region_start <= cfg_data;
        CFG_SPILL_LIMIT:  cfg.spill_limit  <= cfg_data[SIZE_W-1:0];
        CFG_TAPE_BASE:    cfg.tape_base    <= cfg_data;
        CFG_REVERSE_MODE: cfg.reverse_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Process the held word when the output register can take its result
  assign fire     = in_q_valid && (!out_valid || !out_stall);
  assign in_stall = in_q_valid && !fire;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (!in_stall) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_q <= in_data;
    end
  end

  stsa_hist u_hist (
    .clk  (clk),
    .rst  (rst),
    .cmd  (hist_cmd),
    .stat (hist_stat)
  );

  stsa_core u_core (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .item      (in_q),
    .cfg       (cfg),
    .hist_stat (hist_stat),
    .hist_cmd  (hist_cmd),
    .result    (result)
  );

  // Output register: hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= fire || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data <= result;
    end
  end

  // Checks
  `STSA_ASSERT_NOW(a_req_ok, out_valid && out_data.mem_valid, out_data.status == ST_OK)
  `STSA_ASSERT_NOW(a_cnt_max, 1'b1, hist_stat.count <= HIST_CNT_W'(HIST_DEPTH))
  `STSA_ASSERT_NEXT(a_push_cnt, hist_cmd.push, hist_stat.count == $past(hist_stat.count) + 1'b1)
  `STSA_ASSERT_NEXT(a_pop_cnt, hist_cmd.pop, hist_stat.count == $past(hist_stat.count) - 1'b1)

endmodule

`default_nettype wire

### dv/scratchpad_tape_spill_allocator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scratchpad tape spill allocator testbench
// Sends allocate and address words with random gaps and output stalls. A
// shadow copy of the region, tape pointer and spill stack predicts every
// result word. The test runs directed corner cases, a stack overflow and
// drain sequence, and random phases under changing register settings.
// ----------------------------------------------------------------------------

module scratchpad_tape_spill_allocator_tb;
  import stsa_pkg::*;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_stall;
  in_word_t             in_data;
  logic                 out_valid;
  logic                 out_stall;
  out_word_t            out_data;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [ADDR_W-1:0]    cfg_data;

  scratchpad_tape_spill_allocator dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Shadow registers
  logic [ADDR_W-1:0] base_addr;
  logic [SIZE_W-1:0] spill_at;
  logic [ADDR_W-1:0] tape_start;
  logic              rewinding;

  // Shadow allocator state
  logic [FILL_W-1:0] fill_bytes;
  logic [FILL_W-1:0] head_bytes;
  logic [ADDR_W-1:0] tape_pos;
  logic [SIZE_W-1:0] spill_sizes [HIST_DEPTH];
  int unsigned       stack_depth;

  out_word_t awaited_results[$];
  int mismatch_count;
  int words_sent;
  int spills;
  int refills;
  int refusals;
  int empty_pops;
  bit src_gaps;
  bit sink_gaps;

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Run limit
  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  // Gap length: mostly short, a few long
  function automatic int draw_gap(input bit enabled);
    int pick;
    if (!enabled) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Advance the shadow allocator by one word and build its result
  function automatic out_word_t predict_allocation(input in_word_t w);
    out_word_t   r;
    logic [22:0] grown;
    logic [SIZE_W-1:0] sz;
    r = '0;
    r.status = ST_OK;
    if (w.req_type == REQ_ADDR) begin
      r.access_addr = base_addr + ADDR_W'(head_bytes) + (ADDR_W'(w.elem_index) << 3);
    end else if (!rewinding) begin
      // Spill the region, clamped to SIZE_MAX, when the request would reach the limit
      if ({1'b0, fill_bytes} + 23'(w.alloc_size) >= 23'(spill_at)) begin
        if (stack_depth >= HIST_DEPTH) begin
          r.status = ST_FULL;
          refusals++;
        end else begin
          sz = (fill_bytes > {1'b0, SIZE_MAX}) ? SIZE_MAX : fill_bytes[SIZE_W-1:0];
          r.mem_valid = 1'b1;
          r.mem_write = 1'b1;
          r.mem_addr  = tape_start + tape_pos;
          r.mem_size  = sz;
          spill_sizes[stack_depth] = sz;
          stack_depth++;
          tape_pos   = tape_pos + ADDR_W'(sz);
          fill_bytes = '0;
          spills++;
        end
      end
      head_bytes = fill_bytes;
      grown = {1'b0, fill_bytes} + 23'(w.alloc_size);
      fill_bytes = (grown > {1'b0, FILL_MAX}) ? FILL_MAX : grown[FILL_W-1:0];
    end else begin
      // Refill an empty region from the top of the stack
      if (fill_bytes == '0) begin
        if (stack_depth == 0) begin
          r.status = ST_EMPTY;
          empty_pops++;
        end else begin
          sz = spill_sizes[stack_depth-1];
          stack_depth--;
          tape_pos    = tape_pos - ADDR_W'(sz);
          r.mem_valid = 1'b1;
          r.mem_write = 1'b0;
          r.mem_addr  = tape_start + tape_pos;
          r.mem_size  = sz;
          fill_bytes  = FILL_W'(sz);
          refills++;
        end
      end
      fill_bytes = (fill_bytes > FILL_W'(w.alloc_size)) ?
                   fill_bytes - FILL_W'(w.alloc_size) : '0;
      head_bytes = fill_bytes;
    end
    r.head_addr = base_addr + ADDR_W'(head_bytes);
    return r;
  endfunction

  // Send one word; predict it at the edge that accepts it
  task automatic send_word(input in_word_t w);
    int        gap;
    out_word_t predicted;
    gap = draw_gap(src_gaps);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      in_data  <= in_word_t'($urandom);
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = predict_allocation(w);
    awaited_results = {awaited_results, predicted};
    words_sent++;
  endtask

  task automatic send_alloc(input int unsigned bytes);
    in_word_t w;
    w.req_type   = REQ_ALLOC;
    w.alloc_size = ALLOC_W'(bytes);
    w.elem_index = INDEX_W'($urandom);
    send_word(w);
  endtask

  task automatic send_index(input int unsigned idx);
    in_word_t w;
    w.req_type   = REQ_ADDR;
    w.alloc_size = ALLOC_W'($urandom);
    w.elem_index = INDEX_W'(idx);
    send_word(w);
  endtask

  // Drop valid and wait until every result is back and the pipe is empty
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write one register and mirror it in the shadow copy
  task automatic write_reg(input cfg_idx_t idx, input logic [ADDR_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      CFG_REGION_START: base_addr  = val;
      CFG_SPILL_LIMIT:  spill_at   = val[SIZE_W-1:0];
      CFG_TAPE_BASE:    tape_start = val;
      CFG_REVERSE_MODE: rewinding  = val[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [ADDR_W-1:0] pick_address();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return '1;
      default: return ADDR_W'($urandom);
    endcase
  endfunction

  function automatic logic [ADDR_W-1:0] pick_limit();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return 1;
      2: return 32'd1048576;
      3: return 32'(SIZE_MAX);
      4, 5, 6: return $urandom_range(1, 4096);
      default: return $urandom_range(1, 2097151);
    endcase
  endfunction

  // Random word with sizes scaled to the current limit
  function automatic in_word_t random_word();
    in_word_t    w;
    int unsigned span;
    span = spill_at >> 1;
    if (span > 32'hFFFFF) span = 32'hFFFFF;
    w.req_type = ($urandom_range(0, 3) == 0) ? REQ_ADDR : REQ_ALLOC;
    case ($urandom_range(0, 9))
      0: w.elem_index = '0;
      1: w.elem_index = '1;
      default: w.elem_index = INDEX_W'($urandom);
    endcase
    case ($urandom_range(0, 9))
      0: w.alloc_size = '0;
      1: w.alloc_size = '1;
      2, 3: w.alloc_size = ALLOC_W'($urandom);
      default: w.alloc_size = ALLOC_W'($urandom_range(0, span));
    endcase
    return w;
  endfunction

  // Output stall generator
  initial begin
    int len;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      len = draw_gap(sink_gaps);
      if (len > 0) begin
        out_stall <= 1'b1;
        repeat (len) @(negedge clk);
      end
      out_stall <= 1'b0;
    end
  end

  // Result checker
  always @(posedge clk) begin
    out_word_t exp;
    if (!rst && out_valid && !out_stall) begin
      if (awaited_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: result word with nothing pending: %h", $realtime, out_data);
      end else begin
        exp = awaited_results.pop_front();
        if (out_data !== exp) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display({"%0t: mismatch exp/act mem_valid %b/%b mem_write %b/%b ",
                      "mem_addr %h/%h mem_size %h/%h head %h/%h access %h/%h ",
                      "status %0d/%0d"}, $realtime,
                     exp.mem_valid, out_data.mem_valid, exp.mem_write, out_data.mem_write,
                     exp.mem_addr, out_data.mem_addr, exp.mem_size, out_data.mem_size,
                     exp.head_addr, out_data.head_addr,
                     exp.access_addr, out_data.access_addr, exp.status, out_data.status);
        end
      end
    end
  end

  // Reset values: address items, an empty spill and a full-size allocate
  task automatic test_reset_defaults();
    send_index(0);
    send_index(16'hFFFF);
    send_alloc(0);
    send_alloc(20'hFFFFF);
    send_alloc(100);
    send_index(3);
  endtask

  // Address and tape pointer sums that wrap past 32 bits
  task automatic test_address_wrap();
    settle();
    write_reg(CFG_REGION_START, 32'hFFFF_FFF0);
    write_reg(CFG_TAPE_BASE, 32'hFFFF_FFFF);
    send_index(16'hFFFF);
    send_alloc(65536);
    send_index(2);
  endtask

  // Zero limit: every forward allocate spills, even an empty region
  task automatic test_zero_limit();
    settle();
    write_reg(CFG_SPILL_LIMIT, 0);
    send_alloc(0);
    send_alloc(0);
    send_alloc(7);
    send_index(1);
  endtask

  // Reverse mode: refill every spilled frame, then pop past empty
  task automatic test_refill_to_empty();
    int n;
    settle();
    write_reg(CFG_SPILL_LIMIT, 32'(SIZE_MAX));
    write_reg(CFG_REVERSE_MODE, 1);
    n = stack_depth + 3;
    send_alloc(0);
    repeat (n) send_alloc(20'hFFFFF);
    send_index(5);
  endtask

  // Fill the stack, get refused spills and a saturated fill, then drain it
  task automatic test_history_overflow();
    int k;
    settle();
    src_gaps  = 1'b1;
    sink_gaps = 1'b1;
    write_reg(CFG_REGION_START, pick_address());
    write_reg(CFG_TAPE_BASE, pick_address());
    write_reg(CFG_SPILL_LIMIT, 1);
    write_reg(CFG_REVERSE_MODE, 0);
    for (k = 0; k < HIST_DEPTH + 6; k++) begin
      if (k % 10 == 9) send_index($urandom);
      send_alloc($urandom_range(1, 4096));
    end
    repeat (6) send_alloc(20'hFFFFF);
    send_index($urandom);
    settle();
    write_reg(CFG_REVERSE_MODE, 1);
    repeat (HIST_DEPTH + 10) send_alloc(20'hFFFFF);
  endtask

  // Random phases under changing register settings and idle patterns
  task automatic test_random_phases(input int target);
    int goal;
    int len;
    goal = words_sent + target;
    while (words_sent < goal) begin
      settle();
      src_gaps  = ($urandom_range(0, 3) != 0);
      sink_gaps = ($urandom_range(0, 3) != 0);
      write_reg(CFG_REGION_START, pick_address());
      write_reg(CFG_SPILL_LIMIT, pick_limit());
      write_reg(CFG_TAPE_BASE, pick_address());
      write_reg(CFG_REVERSE_MODE, ($urandom_range(0, 9) < 6) ? 0 : 1);
      len = rewinding ? $urandom_range(20, 60) : $urandom_range(40, 120);
      repeat (len) send_word(random_word());
    end
  endtask

  // Main sequence
  initial begin
    int k;
    rst            = 1'b1;
    in_valid       = 1'b0;
    in_data        = '0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    src_gaps       = 1'b1;
    sink_gaps      = 1'b1;
    mismatch_count = 0;
    words_sent     = 0;
    spills         = 0;
    refills        = 0;
    refusals       = 0;
    empty_pops     = 0;
    base_addr      = '0;
    spill_at       = SIZE_W'(65536);
    tape_start     = '0;
    rewinding      = 1'b0;
    fill_bytes     = '0;
    head_bytes     = '0;
    tape_pos       = '0;
    stack_depth    = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_address_wrap();
    test_zero_limit();
    test_refill_to_empty();
    test_history_overflow();
    test_random_phases(650);

    // Drain with the output side open
    @(negedge clk);
    in_valid <= 1'b0;
    sink_gaps = 1'b0;
    for (k = 0; k < 5000 && awaited_results.size() != 0; k++) @(posedge clk);
    repeat (4) @(posedge clk);
    mismatch_count += awaited_results.size();

    $display("Sent %0d words: %0d spills, %0d refills, %0d refused pushes,",
             words_sent, spills, refills, refusals);
    $display("%0d pops on an empty stack, %0d failures.", empty_pops, mismatch_count);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
